FILE: rtl/fpa_pkg.sv
// Shared command and status codes and default sizes for the fixed-point ALU.
package fpa_pkg;

  localparam int DEF_FRACTION_BITS = 8;
  localparam int DEF_WORD_WIDTH    = 32;
  localparam int CMD_W             = 4;
  localparam int STATUS_W          = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_ADD      = 4'd0,
    CMD_SUB      = 4'd1,
    CMD_MUL      = 4'd2,
    CMD_DIV      = 4'd3,
    CMD_INC      = 4'd4,
    CMD_DEC      = 4'd5,
    CMD_GT       = 4'd6,
    CMD_LT       = 4'd7,
    CMD_GE       = 4'd8,
    CMD_LE       = 4'd9,
    CMD_EQ       = 4'd10,
    CMD_MIN      = 4'd11,
    CMD_MAX      = 4'd12,
    CMD_TO_INT   = 4'd13,
    CMD_FROM_INT = 4'd14,
    CMD_NONE     = 4'd15
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK   = 2'd0,
    ST_OVF  = 2'd1,
    ST_DIV0 = 2'd2
  } status_t;

endpackage

FILE: rtl/fpa_div.sv
// Pipelined restoring divider: one quotient bit per stage, quotient and remainder out.
module fpa_div #(
  parameter int WORD_WIDTH    = 32,
  parameter int QUOTIENT_BITS = 40
) (
  input  logic                     clk,
  input  logic [QUOTIENT_BITS-1:0] dividend,
  input  logic [WORD_WIDTH-1:0]    divisor,
  output logic [QUOTIENT_BITS-1:0] quotient,
  output logic [WORD_WIDTH-1:0]    remainder,
  output logic [WORD_WIDTH-1:0]    divisor_out
);

  logic [WORD_WIDTH-1:0]    rem_r [1:QUOTIENT_BITS];
  logic [QUOTIENT_BITS-1:0] dq_r  [1:QUOTIENT_BITS];
  logic [WORD_WIDTH-1:0]    dvs_r [1:QUOTIENT_BITS];

  for (genvar i = 0; i < QUOTIENT_BITS; i++) begin : g_stage
    logic [WORD_WIDTH-1:0]    rem_in;
    logic [QUOTIENT_BITS-1:0] dq_in;
    logic [WORD_WIDTH-1:0]    dvs_in;
    logic [WORD_WIDTH:0]      rs;
    logic                     ge;
    logic [WORD_WIDTH:0]      diff;
    logic [WORD_WIDTH-1:0]    rem_nxt;
    logic [QUOTIENT_BITS-1:0] dq_nxt;

    if (i == 0) begin : g_first
      assign rem_in = '0;
      assign dq_in  = dividend;
      assign dvs_in = divisor;
    end else begin : g_next
      assign rem_in = rem_r[i];
      assign dq_in  = dq_r[i];
      assign dvs_in = dvs_r[i];
    end

    always_comb begin
      // bring down the next dividend bit, then try the subtract
      rs      = {rem_in, dq_in[QUOTIENT_BITS-1]};
      ge      = (rs >= {1'b0, dvs_in});
      diff    = rs - {1'b0, dvs_in};
      rem_nxt = ge ? diff[WORD_WIDTH-1:0] : rs[WORD_WIDTH-1:0];
      dq_nxt  = {dq_in[QUOTIENT_BITS-2:0], ge};
    end

    always_ff @(posedge clk) begin
      rem_r[i+1] <= rem_nxt;
      dq_r[i+1]  <= dq_nxt;
      dvs_r[i+1] <= dvs_in;
    end
  end

  assign quotient    = dq_r[QUOTIENT_BITS];
  assign remainder   = rem_r[QUOTIENT_BITS];
  assign divisor_out = dvs_r[QUOTIENT_BITS];

endmodule

FILE: rtl/fixed_point_alu_top.sv
// Top level of the pipelined signed fixed-point ALU.
//
// Usage: drive in_command, in_operand_a and in_operand_b and raise start; the
// word is taken at each rising edge where start is high and busy is low. busy
// stays low, so a new word may enter in every clock cycle.
// Each word gives exactly one result, shown for one cycle with out_valid high
// on out_result_value, out_compare_true and out_status. Results leave in the
// order the words came in.
// Every command takes the same path from accept to out_valid, its length set
// by the divider, which resolves one quotient bit per pipeline stage.
// Throughput: one word per cycle.
// The multiplier is one full-width product followed by a rounding stage.
// Reset (synchronous, rst_n low) clears all valid bits; words in flight are
// dropped. The receiver cannot stall, so nothing ever holds the pipeline.
module fixed_point_alu_top
  import fpa_pkg::*;
#(
  parameter int FRACTION_BITS = DEF_FRACTION_BITS,
  parameter int WORD_WIDTH    = DEF_WORD_WIDTH
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic [CMD_W-1:0]             in_command,
  input  logic signed [WORD_WIDTH-1:0] in_operand_a,
  input  logic signed [WORD_WIDTH-1:0] in_operand_b,
  output logic                         out_valid,
  output logic signed [WORD_WIDTH-1:0] out_result_value,
  output logic                         out_compare_true,
  output logic [STATUS_W-1:0]          out_status
);

  localparam int QW     = WORD_WIDTH + FRACTION_BITS;
  localparam int MW     = (2 * WORD_WIDTH > QW + 1) ? 2 * WORD_WIDTH : QW + 1;
  localparam int SW     = WORD_WIDTH + FRACTION_BITS + 2;
  localparam int DLY    = QW - 1;
  localparam int SIDE_W = WORD_WIDTH + 1 + STATUS_W + CMD_W + 2;

  localparam logic [MW-1:0] POS_MAX = MW'((64'd1 << (WORD_WIDTH - 1)) - 64'd1);
  localparam logic [MW-1:0] NEG_MAX = MW'(64'd1 << (WORD_WIDTH - 1));
  localparam logic signed [SW-1:0] S_HI = SW'(signed'(POS_MAX));
  localparam logic signed [SW-1:0] S_LO = -S_HI - SW'(1);

  // saturate a signed wide value to the word range
  function automatic logic [WORD_WIDTH:0] sat_s(input logic signed [SW-1:0] v);
    logic [WORD_WIDTH:0] r;
    if (v > S_HI)      r = {1'b1, S_HI[WORD_WIDTH-1:0]};
    else if (v < S_LO) r = {1'b1, S_LO[WORD_WIDTH-1:0]};
    else               r = {1'b0, v[WORD_WIDTH-1:0]};
    return r;
  endfunction

  // apply a sign to a magnitude and saturate
  function automatic logic [WORD_WIDTH:0] sat_m(input logic [MW-1:0] mag, input logic neg);
    logic [WORD_WIDTH:0] r;
    logic [MW-1:0]       t;
    t = '0 - mag;
    if (neg) begin
      if (mag > NEG_MAX) r = {1'b1, NEG_MAX[WORD_WIDTH-1:0]};
      else               r = {1'b0, t[WORD_WIDTH-1:0]};
    end else begin
      if (mag > POS_MAX) r = {1'b1, POS_MAX[WORD_WIDTH-1:0]};
      else               r = {1'b0, mag[WORD_WIDTH-1:0]};
    end
    return r;
  endfunction

  assign busy = 1'b0;

  // stage 1: input register
  logic                         v1_r;
  logic [CMD_W-1:0]             cmd1_r;
  logic signed [WORD_WIDTH-1:0] a1_r, b1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v1_r <= 1'b0;
    else        v1_r <= start;
    cmd1_r <= in_command;
    a1_r   <= in_operand_a;
    b1_r   <= in_operand_b;
  end

  // stage 1 logic: magnitudes and the simple ops
  logic [WORD_WIDTH-1:0]        ma1, mb1;
  logic                         neg1;
  logic signed [SW-1:0]         a1s, b1s;
  logic [WORD_WIDTH:0]          sat1;
  logic signed [WORD_WIDTH-1:0] res1;
  logic                         cmp1;
  logic [STATUS_W-1:0]          st1;

  always_comb begin
    ma1  = a1_r[WORD_WIDTH-1] ? WORD_WIDTH'(-a1_r) : WORD_WIDTH'(a1_r);
    mb1  = b1_r[WORD_WIDTH-1] ? WORD_WIDTH'(-b1_r) : WORD_WIDTH'(b1_r);
    neg1 = a1_r[WORD_WIDTH-1] ^ b1_r[WORD_WIDTH-1];
    a1s  = SW'(a1_r);
    b1s  = SW'(b1_r);
    sat1 = '0;
    res1 = '0;
    cmp1 = 1'b0;
    st1  = ST_OK;
    case (cmd1_r)
      CMD_ADD:      sat1 = sat_s(a1s + b1s);
      CMD_SUB:      sat1 = sat_s(a1s - b1s);
      CMD_INC:      sat1 = sat_s(a1s + SW'(1));
      CMD_DEC:      sat1 = sat_s(a1s - SW'(1));
      CMD_FROM_INT: sat1 = sat_s(b1s <<< FRACTION_BITS);
      default:      sat1 = '0;
    endcase
    case (cmd1_r)
      CMD_ADD, CMD_SUB, CMD_INC, CMD_DEC, CMD_FROM_INT: begin
        res1 = sat1[WORD_WIDTH-1:0];
        st1  = sat1[WORD_WIDTH] ? ST_OVF : ST_OK;
      end
      CMD_GT:     cmp1 = (a1_r > b1_r);
      CMD_LT:     cmp1 = (a1_r < b1_r);
      CMD_GE:     cmp1 = (a1_r >= b1_r);
      CMD_LE:     cmp1 = (a1_r <= b1_r);
      CMD_EQ:     cmp1 = (a1_r == b1_r);
      CMD_MIN:    res1 = (a1_r < b1_r) ? a1_r : b1_r;
      CMD_MAX:    res1 = (a1_r > b1_r) ? a1_r : b1_r;
      CMD_TO_INT: res1 = a1_r >>> FRACTION_BITS;
      default:    res1 = '0;
    endcase
  end

  // divider fed from stage 1
  logic [QW-1:0]         div_q;
  logic [WORD_WIDTH-1:0] div_rem, div_dvs;

  fpa_div #(
    .WORD_WIDTH   (WORD_WIDTH),
    .QUOTIENT_BITS(QW)
  ) u_div (
    .clk        (clk),
    .dividend   ({ma1, FRACTION_BITS'(0)}),
    .divisor    (mb1),
    .quotient   (div_q),
    .remainder  (div_rem),
    .divisor_out(div_dvs)
  );

  // stage 2: product register
  logic                         v2_r;
  logic [CMD_W-1:0]             cmd2_r;
  logic                         neg2_r, divz2_r, cmp2_r;
  logic signed [WORD_WIDTH-1:0] res2_r;
  logic [STATUS_W-1:0]          st2_r;
  logic [2*WORD_WIDTH-1:0]      prod2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v2_r <= 1'b0;
    else        v2_r <= v1_r;
    cmd2_r  <= cmd1_r;
    neg2_r  <= neg1;
    divz2_r <= (b1_r == '0);
    cmp2_r  <= cmp1;
    res2_r  <= res1;
    st2_r   <= st1;
    prod2_r <= (2*WORD_WIDTH)'(ma1) * (2*WORD_WIDTH)'(mb1);
  end

  // stage 3: round and saturate the product
  logic [2*WORD_WIDTH-1:0] prod_rnd;
  logic [WORD_WIDTH:0]     sat2;
  logic [SIDE_W-1:0]       side3_nxt;
  logic [SIDE_W-1:0]       side_r [DLY];
  logic [DLY-1:0]          vline_r;

  always_comb begin
    prod_rnd = (prod2_r + ((2*WORD_WIDTH)'(1) << (FRACTION_BITS - 1))) >> FRACTION_BITS;
    sat2     = sat_m(MW'(prod_rnd), neg2_r);
    if (cmd2_r == CMD_MUL)
      side3_nxt = {sat2[WORD_WIDTH-1:0], cmp2_r,
                   sat2[WORD_WIDTH] ? ST_OVF : ST_OK, cmd2_r, neg2_r, divz2_r};
    else
      side3_nxt = {res2_r, cmp2_r, st2_r, cmd2_r, neg2_r, divz2_r};
  end

  // advance the side data in step with the divider
  always_ff @(posedge clk) begin
    if (!rst_n) vline_r <= '0;
    else        vline_r <= {vline_r[DLY-2:0], v2_r};
    side_r[0] <= side3_nxt;
    for (int k = 1; k < DLY; k++) side_r[k] <= side_r[k-1];
  end

  // final stage: divider rounding and result select
  logic [SIDE_W-1:0]            side_end;
  logic signed [WORD_WIDTH-1:0] e_res;
  logic                         e_cmp, e_neg, e_divz;
  logic [STATUS_W-1:0]          e_st;
  logic [CMD_W-1:0]             e_cmd;
  logic                         rnd_up;
  logic [QW:0]                  qr;
  logic [WORD_WIDTH:0]          satd;
  logic signed [WORD_WIDTH-1:0] res_nxt;
  logic [STATUS_W-1:0]          st_nxt;

  always_comb begin
    side_end = side_r[DLY-1];
    {e_res, e_cmp, e_st, e_cmd, e_neg, e_divz} = side_end;
    // round half away: bump when twice the remainder reaches the divisor
    rnd_up  = ({div_rem, 1'b0} >= {1'b0, div_dvs});
    qr      = {1'b0, div_q} + (QW+1)'(rnd_up);
    satd    = sat_m(MW'(qr), e_neg);
    res_nxt = e_res;
    st_nxt  = e_st;
    if (e_cmd == CMD_DIV) begin
      if (e_divz) begin
        res_nxt = '0;
        st_nxt  = ST_DIV0;
      end else begin
        res_nxt = satd[WORD_WIDTH-1:0];
        st_nxt  = satd[WORD_WIDTH] ? ST_OVF : ST_OK;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid <= 1'b0;
    else        out_valid <= vline_r[DLY-1];
    out_result_value <= res_nxt;
    out_compare_true <= e_cmp;
    out_status       <= st_nxt;
  end

endmodule

FILE: tb/tb_fixed_point_alu_top.sv
// Self-checking testbench for the pipelined fixed-point ALU top level.
module tb_fixed_point_alu_top;
  timeunit 1ns;
  timeprecision 1ps;
  import fpa_pkg::*;

  localparam int FB = DEF_FRACTION_BITS;
  localparam int WW = DEF_WORD_WIDTH;
  localparam int LATENCY = WW + FB + 1;
  localparam int CYCLE_LIMIT = 200000;

  typedef struct packed {
    logic signed [WW-1:0] value;
    logic                 cmp;
    logic [STATUS_W-1:0]  status;
  } alu_word_t;

  int error_count = 0;

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t: %s", $realtime, msg);
    error_count++;
  endtask

  // Holds the expected ALU answers in issue order.
  class alu_scoreboard;
    alu_word_t pending[$];

    function automatic longint sat(longint v, ref logic [STATUS_W-1:0] st);
      longint hi, lo;
      hi = (longint'(1) <<< (WW - 1)) - 1;
      lo = -hi - 1;
      if (v > hi) begin st = ST_OVF; return hi; end
      if (v < lo) begin st = ST_OVF; return lo; end
      return v;
    endfunction

    function automatic alu_word_t compute(cmd_t cmd, logic signed [WW-1:0] a_in,
                                          logic signed [WW-1:0] b_in);
      alu_word_t r;
      longint a, b, res;
      longint unsigned ma, mb, p, q;
      logic [STATUS_W-1:0] st;
      logic neg;
      a = a_in; b = b_in; res = 0; st = ST_OK; r.cmp = 0;
      neg = (a < 0) != (b < 0);
      ma = a < 0 ? -a : a;
      mb = b < 0 ? -b : b;
      case (cmd)
        CMD_ADD: res = sat(a + b, st);
        CMD_SUB: res = sat(a - b, st);
        CMD_MUL: begin
          p = ma * mb;
          q = (p + (64'd1 << (FB - 1))) >> FB;
          res = sat(neg ? -longint'(q) : longint'(q), st);
        end
        CMD_DIV: begin
          if (b == 0) begin
            res = 0; st = ST_DIV0;
          end else begin
            q = (2 * (ma << FB) + mb) / (2 * mb);
            res = sat(neg ? -longint'(q) : longint'(q), st);
          end
        end
        CMD_INC: res = sat(a + 1, st);
        CMD_DEC: res = sat(a - 1, st);
        CMD_GT: r.cmp = a > b;
        CMD_LT: r.cmp = a < b;
        CMD_GE: r.cmp = a >= b;
        CMD_LE: r.cmp = a <= b;
        CMD_EQ: r.cmp = a == b;
        CMD_MIN: res = a < b ? a : b;
        CMD_MAX: res = a > b ? a : b;
        CMD_TO_INT: res = a >>> FB;
        CMD_FROM_INT: res = sat(b * (longint'(1) <<< FB), st);
        default: res = 0;
      endcase
      r.value = res[WW-1:0];
      r.status = st;
      return r;
    endfunction

    function void note_word(logic [CMD_W-1:0] cmd, logic signed [WW-1:0] a,
                            logic signed [WW-1:0] b);
      pending.push_back(compute(cmd_t'(cmd), a, b));
    endfunction

    task automatic check_result(alu_word_t got);
      alu_word_t exp_w;
      if (pending.size() == 0) begin
        report_mismatch("result with nothing pending");
        return;
      end
      exp_w = pending.pop_front();
      if (got.value !== exp_w.value)
        report_mismatch($sformatf("value got %h want %h", got.value, exp_w.value));
      if (got.cmp !== exp_w.cmp)
        report_mismatch($sformatf("compare got %b want %b", got.cmp, exp_w.cmp));
      if (got.status !== exp_w.status)
        report_mismatch($sformatf("status got %0d want %0d", got.status, exp_w.status));
    endtask
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic start = 0;
  logic busy;
  logic [CMD_W-1:0] in_command = '0;
  logic signed [WW-1:0] in_operand_a = '0;
  logic signed [WW-1:0] in_operand_b = '0;
  logic out_valid;
  logic signed [WW-1:0] out_result_value;
  logic out_compare_true;
  logic [STATUS_W-1:0] out_status;

  alu_scoreboard alu_sb = new();
  int idle_pct = 0;
  int cycle_count = 0;

  always #10 clk = ~clk;

  fixed_point_alu_top DUT (.*);

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (rst_n && start && !busy)
      alu_sb.note_word(in_command, in_operand_a, in_operand_b);
    if (rst_n && out_valid)
      alu_sb.check_result({out_result_value, out_compare_true, out_status});
    if (cycle_count > CYCLE_LIMIT) begin
      $display("** fixed_point_alu_top: FAILED **");
      $finish;
    end
  end

  // Issue one word, with random idle cycles ahead of it.
  task automatic send_word(input logic [CMD_W-1:0] cmd, input logic [WW-1:0] a,
                           input logic [WW-1:0] b);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    in_command <= cmd;
    in_operand_a <= a;
    in_operand_b <= b;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  function automatic logic [WW-1:0] rand_operand();
    case ($urandom_range(5))
      0: return {$urandom()};
      1: return $urandom_range(4095) - 2048;
      2: return {1'b0, {(WW-1){1'b1}}} - $urandom_range(3);
      3: return {1'b1, {(WW-1){1'b0}}} + $urandom_range(3);
      4: return $signed({$urandom()}) >>> $urandom_range(31);
      default: return $urandom_range(2) - 1;
    endcase
  endfunction

  task automatic drain();
    start <= 1'b0;
    while (alu_sb.pending.size() != 0) @(posedge clk);
  endtask

  localparam logic [WW-1:0] MAXV = {1'b0, {(WW-1){1'b1}}};
  localparam logic [WW-1:0] MINV = {1'b1, {(WW-1){1'b0}}};

  initial begin
    logic [WW-1:0] a, b;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // directed corners
    send_word(CMD_ADD, MAXV, 1);
    send_word(CMD_SUB, MINV, 1);
    send_word(CMD_MUL, MAXV, MAXV);
    send_word(CMD_MUL, MINV, MAXV);
    send_word(CMD_MUL, 32'h180, 32'hFFFF_FF80);
    send_word(CMD_DIV, 32'h100, 0);
    send_word(CMD_DIV, MINV, 32'hFFFF_FFFF);
    send_word(CMD_DIV, 32'h100, 32'h300);
    send_word(CMD_INC, MAXV, 0);
    send_word(CMD_DEC, MINV, 0);
    send_word(CMD_GT, MAXV, MINV);
    send_word(CMD_LT, MAXV, MINV);
    send_word(CMD_GE, 5, 5);
    send_word(CMD_LE, MINV, MINV);
    send_word(CMD_EQ, 5, 5);
    send_word(CMD_MIN, MAXV, MINV);
    send_word(CMD_MAX, MAXV, MINV);
    send_word(CMD_TO_INT, 32'hFFFF_FF01, 0);
    send_word(CMD_TO_INT, MAXV, 0);
    send_word(CMD_FROM_INT, 0, MAXV);
    send_word(CMD_FROM_INT, 0, MINV);
    send_word(CMD_NONE, MAXV, MINV);
    drain();
    // random words in four phases of differing idle share, each drained before the next
    for (int phase = 0; phase < 4; phase++) begin
      idle_pct = (phase == 1 || phase == 2) ? 66 : (phase == 3 ? 11 : 0);
      for (int i = 0; i < 400; i++) begin
        a = rand_operand();
        b = rand_operand();
        send_word(CMD_W'($urandom_range(15)), a, b);
      end
      drain();
    end
    repeat (LATENCY + 10) @(posedge clk);
    if (error_count == 0 && alu_sb.pending.size() == 0)
      $display("** fixed_point_alu_top: PASSED **");
    else
      $display("** fixed_point_alu_top: FAILED **");
    $finish;
  end
endmodule
